// File: sv/tpe_pkg.sv
// Shared constants and types for the TCP payload extractor.
`default_nettype none

package tpe_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int SNAP_BITS = 16;
  localparam logic [SNAP_BITS-1:0] SNAP_RESET = 16'd1024;

  // Frame layout, in bytes.
  localparam int ETH_LEN = 14;
  localparam int ETHERTYPE_HI_POS = 12;
  localparam int ETHERTYPE_LO_POS = 13;
  localparam int IP_PROTO_OFFSET = 9;
  localparam int IP_SRC_OFFSET = 12;
  localparam int IP_SRC_BYTES = 4;
  localparam int TCP_DOFF_OFFSET = 12;
  localparam int MIN_HDR_BYTES = 20;

  localparam logic [7:0] ETHERTYPE_IPV4_HI = 8'h08;
  localparam logic [7:0] ETHERTYPE_IPV4_LO = 8'h00;
  localparam logic [7:0] IP_PROTO_TCP = 8'd6;

  typedef struct packed {
    logic        emit;
    logic [7:0]  payload_byte;
    logic [31:0] source_ip;
    logic        first_byte;
    logic        last_byte;
  } tpe_result_t;

endpackage

`default_nettype wire

// File: sv/tpe_if.sv
// Request channel interfaces for frame bytes in and payload bytes out.
`default_nettype none

interface tpe_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface tpe_payload_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [31:0] source_ip;
  logic        first_byte;
  logic        last_byte;

  modport source (output valid, output payload_byte, output source_ip,
                  output first_byte, output last_byte, input ready);
  modport sink (input valid, input payload_byte, input source_ip,
                input first_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: sv/tpe_parser.sv
// Header parser: per-byte state update and payload result decode.
`default_nettype none

module tpe_parser #(
  parameter int POSITION_BITS = tpe_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [7:0]                     data_byte,
  input  logic                           frame_end,
  input  logic [tpe_pkg::SNAP_BITS-1:0]  snap_length,
  output tpe_pkg::tpe_result_t           result
);
  import tpe_pkg::*;

  localparam int EXT = SNAP_BITS + 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  localparam logic [2:0] PH_ETH     = 3'd0;
  localparam logic [2:0] PH_IP      = 3'd1;
  localparam logic [2:0] PH_TCP     = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_DROP    = 3'd4;

  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [2:0]               parse_phase, parse_phase_next;
  logic [7:0]               ethertype_high, ethertype_high_next;
  logic [5:0]               ip_header_bytes, ip_header_bytes_next;
  logic [7:0]               payload_offset, payload_offset_next;
  logic [31:0]              captured_source, captured_source_next;
  logic                     payload_started, payload_started_next;

  logic [EXT-1:0] pos_ext, pos_inc, snap_ext, limit_ext, off_pos;
  logic [5:0]     ihl_bytes, thl_bytes;
  logic           in_window;

  assign pos_ext   = EXT'(byte_position);
  assign pos_inc   = pos_ext + EXT'(1);
  assign snap_ext  = EXT'(snap_length);
  assign limit_ext = (snap_ext < EXT'(POS_MAX)) ? snap_ext : EXT'(POS_MAX);
  assign in_window = pos_ext < limit_ext;
  assign ihl_bytes = {data_byte[3:0], 2'b00};
  assign thl_bytes = {data_byte[7:4], 2'b00};
  assign off_pos   = EXT'(ETH_LEN) + EXT'(ip_header_bytes) + EXT'(TCP_DOFF_OFFSET);

  always_comb begin
    logic [5:0] ihb_eff;
    logic       drop;
    ihb_eff = ip_header_bytes;
    drop    = 1'b0;

    byte_position_next   = byte_position;
    parse_phase_next     = parse_phase;
    ethertype_high_next  = ethertype_high;
    ip_header_bytes_next = ip_header_bytes;
    payload_offset_next  = payload_offset;
    captured_source_next = captured_source;
    payload_started_next = payload_started;

    result.emit         = 1'b0;
    result.payload_byte = data_byte;
    result.source_ip    = captured_source;
    result.first_byte   = ~payload_started;
    result.last_byte    = frame_end || (pos_inc == limit_ext);

    if (step) begin
      if (in_window) begin
        unique case (parse_phase)
          PH_ETH: begin
            if (pos_ext == EXT'(ETHERTYPE_HI_POS)) begin
              ethertype_high_next = data_byte;
            end else if (pos_ext == EXT'(ETHERTYPE_LO_POS)) begin
              parse_phase_next = (ethertype_high == ETHERTYPE_IPV4_HI &&
                                  data_byte == ETHERTYPE_IPV4_LO) ? PH_IP : PH_DROP;
            end
          end
          PH_IP: begin
            if (pos_ext == EXT'(ETH_LEN)) begin
              if (ihl_bytes < 6'(MIN_HDR_BYTES)) begin
                drop = 1'b1;
              end else begin
                ihb_eff = ihl_bytes;
                ip_header_bytes_next = ihl_bytes;
              end
            end
            if (!drop && pos_ext == EXT'(ETH_LEN + IP_PROTO_OFFSET) &&
                data_byte != IP_PROTO_TCP) begin
              drop = 1'b1;
            end
            if (drop) begin
              parse_phase_next = PH_DROP;
            end else begin
              if (pos_ext >= EXT'(ETH_LEN + IP_SRC_OFFSET) &&
                  pos_ext < EXT'(ETH_LEN + IP_SRC_OFFSET + IP_SRC_BYTES)) begin
                captured_source_next = {captured_source[23:0], data_byte};
              end
              if (pos_inc == EXT'(ETH_LEN) + EXT'(ihb_eff)) begin
                parse_phase_next = PH_TCP;
              end
            end
          end
          PH_TCP: begin
            if (pos_ext == off_pos) begin
              if (thl_bytes < 6'(MIN_HDR_BYTES)) begin
                parse_phase_next = PH_DROP;
              end else begin
                payload_offset_next = 8'(ETH_LEN) + 8'(ip_header_bytes) + 8'(thl_bytes);
              end
            end else if (pos_ext > off_pos && pos_inc == EXT'(payload_offset)) begin
              parse_phase_next     = PH_PAYLOAD;
              payload_started_next = 1'b0;
            end
          end
          PH_PAYLOAD: begin
            result.emit          = 1'b1;
            payload_started_next = 1'b1;
          end
          default: begin
          end
        endcase
      end

      if (frame_end) begin
        byte_position_next   = '0;
        parse_phase_next     = PH_ETH;
        payload_started_next = 1'b0;
      end else if (byte_position != POS_MAX) begin
        byte_position_next = byte_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      parse_phase     <= PH_ETH;
      ethertype_high  <= '0;
      ip_header_bytes <= '0;
      payload_offset  <= '0;
      captured_source <= '0;
      payload_started <= 1'b0;
    end else begin
      byte_position   <= byte_position_next;
      parse_phase     <= parse_phase_next;
      ethertype_high  <= ethertype_high_next;
      ip_header_bytes <= ip_header_bytes_next;
      payload_offset  <= payload_offset_next;
      captured_source <= captured_source_next;
      payload_started <= payload_started_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/tcp_payload_extractor_top.sv
// Top level of the TCP payload extractor: config register, parser and output register.
`default_nettype none

// The block takes a captured Ethernet frame one byte per request on the frame
// channel, with frame_end set on the last captured byte, and sends every TCP
// payload byte of an IPv4/TCP frame on the payload channel together with the
// frame's IPv4 source address and first/last marks. Frames with another
// EtherType, another IP protocol, an IHL or data offset below five words, or
// that end before the payload starts produce nothing. Only the first
// snap_length bytes of each frame are looked at (and never beyond the
// saturated byte position 2^POSITION_BITS-1); the byte at the window end is
// marked last. One byte is taken every cycle that the frame channel is ready:
// the header parser updates its state in the same cycle a byte is accepted,
// and any payload byte is held in a single output register, so the frame
// channel stays ready whenever that register is empty or is being emptied by
// the consumer. The user must write snap_length through cfg_we and cfg_wdata
// while no frame is in flight; the block does not enforce it. It resets to 1024.
module tcp_payload_extractor_top #(
  parameter int POSITION_BITS = tpe_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  tpe_frame_if.sink                     frame,
  tpe_payload_if.source                 payload,
  input  logic                          cfg_we,
  input  logic [tpe_pkg::SNAP_BITS-1:0] cfg_wdata
);
  import tpe_pkg::*;

  logic [SNAP_BITS-1:0] snap_length;
  tpe_result_t          result;
  logic                 step;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic [31:0] out_source;
  logic        out_first;
  logic        out_last;

  // A new byte is taken whenever the output register is free or drains now.
  assign frame.ready = ~out_valid | payload.ready;
  assign step        = frame.valid & frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_length <= SNAP_RESET;
    end else if (cfg_we) begin
      snap_length <= cfg_wdata;
    end
  end

  tpe_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data_byte   (frame.data_byte),
    .frame_end   (frame.frame_end),
    .snap_length (snap_length),
    .result      (result)
  );

  // Output register. The valid bit updates whenever the frame channel is ready,
  // to whether an accepted byte produced a payload result; only such a byte loads the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame.ready) begin
      out_valid <= step & result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.emit) begin
      out_byte   <= result.payload_byte;
      out_source <= result.source_ip;
      out_first  <= result.first_byte;
      out_last   <= result.last_byte;
    end
  end

  assign payload.valid        = out_valid;
  assign payload.payload_byte = out_byte;
  assign payload.source_ip    = out_source;
  assign payload.first_byte   = out_first;
  assign payload.last_byte    = out_last;

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the TCP payload extractor, with its own parser prediction.
`timescale 1ns / 100ps

module tb;
  import tpe_pkg::*;

  // The bench runs the block at its widest byte position. The position counter
  // saturates at this value, and a byte seen there is never looked at.
  localparam int POS_BITS = 16;
  localparam int POS_MAX = (1 << POS_BITS) - 1;
  localparam logic [SNAP_BITS-1:0] SNAP_MAX = '1;
  localparam int TIMEOUT_CYCLES = 1000000;

  typedef enum logic [2:0] {PH_ETH, PH_IP, PH_TCP, PH_PAYLOAD, PH_DROP} parse_phase_e;

  // One frame byte waiting to be sent. A byte flagged wait_drained is held back
  // until every predicted payload byte has come out of the block.
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         wait_drained;
  } frame_byte_t;

  typedef struct {
    logic [7:0]  payload_byte;
    logic [31:0] source_ip;
    logic        first_byte;
    logic        last_byte;
  } payload_exp_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [SNAP_BITS-1:0] cfg_wdata;

  tpe_frame_if frame_ch ();
  tpe_payload_if payload_ch ();

  tcp_payload_extractor_top #(
    .POSITION_BITS(POS_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .frame    (frame_ch),
    .payload  (payload_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  frame_byte_t  pending_bytes[$];
  payload_exp_t expected_payload[$];
  frame_byte_t  next_byte;
  payload_exp_t predicted;
  payload_exp_t oldest;
  bit           frame_taken = 1'b0;
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;

  // The parser state as the bench expects it to be. It starts at its reset
  // values, and reset is applied only once, so no reset path is needed here.
  logic [POS_BITS-1:0]  byte_pos = '0;
  parse_phase_e         phase = PH_ETH;
  logic [7:0]           ethertype_hi = '0;
  logic [5:0]           ip_hdr_bytes = '0;
  logic [7:0]           payload_off = '0;
  logic [31:0]          src_addr = '0;
  logic                 payload_seen = 1'b0;
  logic [SNAP_BITS-1:0] snap_len = SNAP_RESET;

  // Advances the parser by one frame byte. It returns 1 when the byte is TCP
  // payload inside the window, and then fills in the payload request the
  // block must send for it.
  function automatic bit predict_payload(input logic [7:0] b, input logic fend,
                                         output payload_exp_t r);
    int p;
    int lim;
    int ihl_bytes;
    int doff_pos;
    int thl;
    bit hit;
    p = int'(byte_pos);
    lim = (int'(snap_len) < POS_MAX) ? int'(snap_len) : POS_MAX;
    ihl_bytes = int'(b[3:0]) * 4;
    thl = int'(b[7:4]) * 4;
    hit = 1'b0;
    r = '{default: '0};
    if (p < lim) begin
      case (phase)
        PH_ETH: begin
          if (p == ETHERTYPE_HI_POS) begin
            ethertype_hi = b;
          end else if (p == ETHERTYPE_LO_POS) begin
            phase = (ethertype_hi == ETHERTYPE_IPV4_HI && b == ETHERTYPE_IPV4_LO) ?
                    PH_IP : PH_DROP;
          end
        end
        PH_IP: begin
          if (p == ETH_LEN && ihl_bytes < MIN_HDR_BYTES) begin
            phase = PH_DROP;
          end else if (p == ETH_LEN + IP_PROTO_OFFSET && b != IP_PROTO_TCP) begin
            phase = PH_DROP;
          end else begin
            if (p == ETH_LEN) ip_hdr_bytes = 6'(ihl_bytes);
            if (p >= ETH_LEN + IP_SRC_OFFSET && p < ETH_LEN + IP_SRC_OFFSET + IP_SRC_BYTES)
              src_addr = {src_addr[23:0], b};
            if (p + 1 == ETH_LEN + int'(ip_hdr_bytes)) phase = PH_TCP;
          end
        end
        PH_TCP: begin
          doff_pos = ETH_LEN + int'(ip_hdr_bytes) + TCP_DOFF_OFFSET;
          if (p == doff_pos) begin
            if (thl < MIN_HDR_BYTES) phase = PH_DROP;
            else payload_off = 8'(ETH_LEN + int'(ip_hdr_bytes) + thl);
          end else if (p > doff_pos && p + 1 == int'(payload_off)) begin
            phase = PH_PAYLOAD;
            payload_seen = 1'b0;
          end
        end
        PH_PAYLOAD: begin
          r.payload_byte = b;
          r.source_ip = src_addr;
          r.first_byte = !payload_seen;
          r.last_byte = fend || (p + 1 == lim);
          payload_seen = 1'b1;
          hit = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (fend) begin
      byte_pos = '0;
      phase = PH_ETH;
      payload_seen = 1'b0;
    end else if (p < POS_MAX) begin
      byte_pos = POS_BITS'(p + 1);
    end
    return hit;
  endfunction

  // Free-running clock with a 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Request driver. Inputs change only at the falling edge, so the block sees
  // them settled at the next rising edge. A new frame byte is offered once the
  // previous request has been taken, unless the sender idles this cycle or the
  // head byte must wait for the payload channel to run dry.
  always @(negedge clk) begin
    if (rst) begin
      frame_ch.valid <= 1'b0;
      payload_ch.ready <= 1'b0;
    end else begin
      if (!frame_ch.valid || frame_taken) begin
        if (pending_bytes.size() != 0 &&
            !(pending_bytes[0].wait_drained && expected_payload.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          next_byte = pending_bytes.pop_front();
          frame_ch.valid <= 1'b1;
          frame_ch.data_byte <= next_byte.data;
          frame_ch.frame_end <= next_byte.last;
        end else begin
          frame_ch.valid <= 1'b0;
        end
      end
      payload_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor. Both channels are sampled at the rising edge, where a request
  // completes when valid and ready are both high. Each payload request is
  // matched against the oldest predicted byte, and each taken frame byte is
  // run through the prediction afterwards, since its result can only show up
  // on a later edge.
  always @(posedge clk) begin
    if (rst) begin
      frame_taken = 1'b0;
    end else begin
      if (payload_ch.valid && payload_ch.ready) begin
        if (expected_payload.size() == 0) begin
          $error("payload request with nothing expected: payload_byte %0h",
                 payload_ch.payload_byte);
          mismatches++;
        end else begin
          oldest = expected_payload.pop_front();
          if (payload_ch.payload_byte !== oldest.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", oldest.payload_byte,
                   payload_ch.payload_byte);
            mismatches++;
          end
          if (payload_ch.source_ip !== oldest.source_ip) begin
            $error("source_ip: expected %0h, got %0h", oldest.source_ip,
                   payload_ch.source_ip);
            mismatches++;
          end
          if (payload_ch.first_byte !== oldest.first_byte) begin
            $error("first_byte: expected %0b, got %0b", oldest.first_byte,
                   payload_ch.first_byte);
            mismatches++;
          end
          if (payload_ch.last_byte !== oldest.last_byte) begin
            $error("last_byte: expected %0b, got %0b", oldest.last_byte,
                   payload_ch.last_byte);
            mismatches++;
          end
        end
      end
      frame_taken = frame_ch.valid && frame_ch.ready;
      if (frame_taken) begin
        if (predict_payload(frame_ch.data_byte, frame_ch.frame_end, predicted))
          expected_payload.push_back(predicted);
      end
    end
  end

  // Queues one frame of total_len bytes. All bytes are random except the
  // EtherType, the IHL nibble, the IP protocol and the TCP data offset nibble,
  // which are forced to the given values at the places the header layout puts
  // them. A frame cut short simply loses the forced fields beyond its end.
  // With pause_late set, the next-to-last byte waits for the payload channel
  // to drain, so the payload bytes before it are all handed over first.
  task automatic queue_frame(input logic [15:0] ethertype, input logic [7:0] proto,
                             input logic [3:0] ihl, input logic [3:0] doff,
                             input int total_len, input bit pause_late);
    int ip_bytes;
    frame_byte_t fb;
    ip_bytes = int'(ihl) * 4;
    for (int i = 0; i < total_len; i++) begin
      fb.data = 8'($urandom);
      if (i == ETHERTYPE_HI_POS) fb.data = ethertype[15:8];
      else if (i == ETHERTYPE_LO_POS) fb.data = ethertype[7:0];
      else if (i == ETH_LEN) fb.data[3:0] = ihl;
      else if (i == ETH_LEN + IP_PROTO_OFFSET) fb.data = proto;
      else if (i == ETH_LEN + ip_bytes + TCP_DOFF_OFFSET) fb.data[7:4] = doff;
      fb.last = (i == total_len - 1);
      fb.wait_drained = pause_late && (i == total_len - 2);
      pending_bytes.push_back(fb);
    end
  endtask

  // A well-formed IPv4/TCP frame carrying pay_len payload bytes.
  task automatic queue_tcp_frame(input logic [3:0] ihl, input logic [3:0] doff,
                                 input int pay_len, input bit pause_late);
    queue_frame({ETHERTYPE_IPV4_HI, ETHERTYPE_IPV4_LO}, IP_PROTO_TCP, ihl, doff,
                ETH_LEN + 4 * int'(ihl) + 4 * int'(doff) + pay_len, pause_late);
  endtask

  // Random traffic of about n_bytes frame bytes. Most frames are well formed
  // with random header sizes and short payloads, so the parser gets all the way
  // to the payload; the rest are frames that each header check must reject,
  // frames cut off inside the headers, and plain noise.
  task automatic queue_random_traffic(input int n_bytes);
    int start;
    int r;
    int hdr;
    int pay;
    logic [3:0] ihl;
    logic [3:0] doff;
    logic [15:0] et;
    logic [7:0] proto;
    start = pending_bytes.size();
    while (pending_bytes.size() - start < n_bytes) begin
      r = $urandom_range(99);
      ihl = 4'($urandom_range(5, 15));
      doff = 4'($urandom_range(5, 15));
      pay = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 12);
      hdr = ETH_LEN + 4 * int'(ihl) + 4 * int'(doff);
      if (r < 68) begin
        queue_tcp_frame(ihl, doff, pay, 1'b0);
      end else if (r < 76) begin
        et = 16'($urandom);
        if (et == {ETHERTYPE_IPV4_HI, ETHERTYPE_IPV4_LO}) et[0] = 1'b1;
        queue_frame(et, IP_PROTO_TCP, ihl, doff, hdr + pay, 1'b0);
      end else if (r < 82) begin
        proto = 8'($urandom);
        if (proto == IP_PROTO_TCP) proto = 8'd17;
        queue_frame({ETHERTYPE_IPV4_HI, ETHERTYPE_IPV4_LO}, proto, ihl, doff, hdr + pay,
                    1'b0);
      end else if (r < 88) begin
        queue_tcp_frame(4'($urandom_range(0, 4)), doff, pay, 1'b0);
      end else if (r < 92) begin
        queue_tcp_frame(ihl, 4'($urandom_range(0, 4)), pay, 1'b0);
      end else if (r < 97) begin
        queue_frame({ETHERTYPE_IPV4_HI, ETHERTYPE_IPV4_LO}, IP_PROTO_TCP, ihl, doff,
                    $urandom_range(1, hdr), 1'b0);
      end else begin
        queue_frame(16'($urandom), 8'($urandom), 4'($urandom), 4'($urandom),
                    $urandom_range(1, 30), 1'b0);
      end
    end
  endtask

  // Waits until every queued byte has been taken and every predicted payload
  // byte has come out, then lets the output register settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || frame_ch.valid || expected_payload.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Writes the snap length while the block is idle, and tells the prediction.
  task automatic set_snap(input logic [SNAP_BITS-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    snap_len = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Main sequence: reset, directed frames under several snap lengths, then
  // random traffic in three idling modes.
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    frame_ch.valid = 1'b0;
    frame_ch.data_byte = '0;
    frame_ch.frame_end = 1'b0;
    payload_ch.ready = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // The sender idles less often than the receiver, so the output register
    // backs up and the frame channel gets throttled.
    send_idle_pct = 31;
    recv_idle_pct = 58;

    // Directed frames at the reset snap length of 1024.
    queue_tcp_frame(4'd5, 4'd5, 3, 1'b0);
    queue_tcp_frame(4'd15, 4'd15, 2, 1'b0);
    // Frames rejected by the EtherType or protocol check; each ends with the
    // protocol byte.
    queue_frame(16'h86DD, IP_PROTO_TCP, 4'd5, 4'd5, 24, 1'b0);
    queue_frame(16'h0801, IP_PROTO_TCP, 4'd5, 4'd5, 24, 1'b0);
    queue_frame({ETHERTYPE_IPV4_HI, ETHERTYPE_IPV4_LO}, 8'd17, 4'd5, 4'd5, 24, 1'b0);
    queue_tcp_frame(4'd4, 4'd5, 1, 1'b0);
    queue_tcp_frame(4'd5, 4'd4, 1, 1'b0);
    // Frames that stop inside the TCP header, right at its end, and after one byte.
    queue_frame({ETHERTYPE_IPV4_HI, ETHERTYPE_IPV4_LO}, IP_PROTO_TCP, 4'd5, 4'd5, 40, 1'b0);
    queue_tcp_frame(4'd5, 4'd5, 0, 1'b0);
    queue_frame({ETHERTYPE_IPV4_HI, ETHERTYPE_IPV4_LO}, IP_PROTO_TCP, 4'd5, 4'd5, 1, 1'b0);

    // A zero snap length lets no byte through at all.
    set_snap('0);
    queue_tcp_frame(4'd5, 4'd5, 2, 1'b0);
    // A window that ends inside the Ethernet header.
    set_snap(16'd13);
    queue_frame({ETHERTYPE_IPV4_HI, ETHERTYPE_IPV4_LO}, IP_PROTO_TCP, 4'd5, 4'd5, 20, 1'b0);
    // A window ending exactly at the payload start gives nothing; six bytes
    // further in, the window end cuts the payload and marks the last byte.
    set_snap(16'd54);
    queue_tcp_frame(4'd5, 4'd5, 2, 1'b0);
    set_snap(16'd60);
    queue_tcp_frame(4'd5, 4'd5, 10, 1'b0);

    set_snap(16'($urandom_range(40, 200)));
    queue_random_traffic(60);

    // Now the receiver is the faster side.
    wait_idle();
    send_idle_pct = 58;
    recv_idle_pct = 31;
    set_snap(16'($urandom_range(80, 1024)));
    // The sender stops near the end of this payload until the payload channel
    // has handed over every byte predicted so far.
    queue_tcp_frame(4'd5, 4'd6, 10, 1'b1);
    set_snap(SNAP_MAX);
    queue_random_traffic(40);

    // No idling on either side from here on.
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_snap(16'($urandom_range(54, 300)));
    queue_random_traffic(60);

    wait_idle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

endmodule
